>>> rtl/cdcg_pkg.sv
// Package: widths, register indexes and shared types of the corner gradient.
`timescale 1ns / 1ps
package cdcg_pkg;
    localparam int MAX_SIDE     = 4096;
    localparam int CHANNEL_BITS = 8;
    localparam int COORD_W      = 12;
    localparam int SIDE_W       = 13;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 13;
    localparam int SQ_W         = 25;                 // dr^2+dc^2 < 2^25
    localparam int RAD_W        = SQ_W + 16;          // radicand with 16 frac bits
    localparam int DIST_W       = RAD_W / 2 + 1;      // 21
    localparam int SUM_W        = DIST_W + 1;         // 22
    localparam int FRAC_W       = 16;
    localparam int NUM_W        = DIST_W + FRAC_W;    // 37
    localparam int WT_W         = FRAC_W + 1;         // 0..65536
    localparam int SQRT_STEPS   = RAD_W / 2 + 1;      // 21 result bits
    localparam int DIV_STEPS    = NUM_W;              // quotient bits

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH   = 3'd0,
        REG_HEIGHT  = 3'd1,
        REG_S_RED   = 3'd2,
        REG_S_GREEN = 3'd3,
        REG_S_BLUE  = 3'd4,
        REG_E_RED   = 3'd5,
        REG_E_GREEN = 3'd6,
        REG_E_BLUE  = 3'd7
    } t_reg_idx;

    typedef logic [CHANNEL_BITS-1:0] t_chan;

    typedef struct packed {
        t_chan s_red;
        t_chan s_green;
        t_chan s_blue;
        t_chan e_red;
        t_chan e_green;
        t_chan e_blue;
    } t_colors;
endpackage

>>> rtl/corner_distance_color_gradient.sv
// Top level: corner-distance color gradient pipeline.
//
// Usage: pulse start with i_pixel_row / i_pixel_col; busy is always low,
// so one item can enter on every clock. Each item's color appears on
// o_red_level / o_green_level / o_blue_level for one cycle with o_done high.
// Pipeline: distance squares, then square root, weight divide and blend;
// throughput one item per cycle, set by the fully
// pipelined bit-per-stage square root and divider.
// Configuration: i_cfg_we with i_cfg_idx / i_cfg_data writes one register
// at once; write only while no item is in flight. Unknown indexes are ignored.
// Reset (synchronous, i_rst_n low) restores 640x480, start magenta-ish
// (255,0,255) and end green (0,255,0), and empties the pipeline.
// The receiver cannot stall: results are strobed and never held.
`timescale 1ns / 1ps
module corner_distance_color_gradient (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [cdcg_pkg::COORD_W-1:0]    i_pixel_row,
    input  logic [cdcg_pkg::COORD_W-1:0]    i_pixel_col,
    output logic                            o_done,
    output logic [7:0]                      o_red_level,
    output logic [7:0]                      o_green_level,
    output logic [7:0]                      o_blue_level,
    input  logic                            i_cfg_we,
    input  logic [cdcg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cdcg_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import cdcg_pkg::*;

    logic [SIDE_W-1:0] r_width, r_height;
    t_colors           r_col;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SIDE_W'(640);
            r_height <= SIDE_W'(480);
            r_col    <= '{s_red: 8'd255, s_green: 8'd0, s_blue: 8'd255,
                          e_red: 8'd0, e_green: 8'd255, e_blue: 8'd0};
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_WIDTH:   r_width       <= i_cfg_data;
                REG_HEIGHT:  r_height      <= i_cfg_data;
                REG_S_RED:   r_col.s_red   <= i_cfg_data[CHANNEL_BITS-1:0];
                REG_S_GREEN: r_col.s_green <= i_cfg_data[CHANNEL_BITS-1:0];
                REG_S_BLUE:  r_col.s_blue  <= i_cfg_data[CHANNEL_BITS-1:0];
                REG_E_RED:   r_col.e_red   <= i_cfg_data[CHANNEL_BITS-1:0];
                REG_E_GREEN: r_col.e_green <= i_cfg_data[CHANNEL_BITS-1:0];
                REG_E_BLUE:  r_col.e_blue  <= i_cfg_data[CHANNEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage A: corner offsets; stage B: squared distances
    logic [SIDE_W-1:0]  n_wm1, n_hm1;
    logic [COORD_W-1:0] r_dr0, r_dc0, r_dr1, r_dc1;
    logic               r_va, r_vb;
    logic [SQ_W-1:0]    r_sq0, r_sq1;

    always_comb begin
        n_wm1 = (r_width == '0) ? '0 :
                (r_width > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE - 1) : r_width - 1'b1;
        n_hm1 = (r_height == '0) ? '0 :
                (r_height > SIDE_W'(MAX_SIDE)) ? SIDE_W'(MAX_SIDE - 1) : r_height - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= start;
            r_vb <= r_va;
        end
        r_dr0 <= i_pixel_row;
        r_dc0 <= i_pixel_col;
        r_dr1 <= ({1'b0, i_pixel_row} >= n_hm1) ? i_pixel_row - n_hm1[COORD_W-1:0]
                                                 : n_hm1[COORD_W-1:0] - i_pixel_row;
        r_dc1 <= ({1'b0, i_pixel_col} >= n_wm1) ? i_pixel_col - n_wm1[COORD_W-1:0]
                                                 : n_wm1[COORD_W-1:0] - i_pixel_col;
        r_sq0 <= (SQ_W'(r_dr0) * SQ_W'(r_dr0)) + (SQ_W'(r_dc0) * SQ_W'(r_dc0));
        r_sq1 <= (SQ_W'(r_dr1) * SQ_W'(r_dr1)) + (SQ_W'(r_dc1) * SQ_W'(r_dc1));
    end

    logic              v_s0, v_s1;
    logic [DIST_W-1:0] d0, d1;

    cdcg_sqrt u_sqrt0 (
        .i_clk, .i_rst_n, .i_valid(r_vb), .i_rad({r_sq0, 16'h0000}),
        .o_valid(v_s0), .o_root(d0)
    );
    cdcg_sqrt u_sqrt1 (
        .i_clk, .i_rst_n, .i_valid(r_vb), .i_rad({r_sq1, 16'h0000}),
        .o_valid(v_s1), .o_root(d1)
    );

    logic              v_d, z_d;
    logic [WT_W-1:0]   w0, w1;
    t_colors           c_d;

    cdcg_div u_div (
        .i_clk, .i_rst_n, .i_valid(v_s0), .i_d0(d0), .i_d1(d1), .i_col(r_col),
        .o_valid(v_d), .o_zero(z_d), .o_w0(w0), .o_w1(w1), .o_col(c_d)
    );

    cdcg_blend u_blend (
        .i_clk, .i_rst_n, .i_valid(v_d), .i_zero(z_d), .i_w0(w0), .i_w1(w1),
        .i_col(c_d), .o_valid(o_done), .o_red(o_red_level),
        .o_green(o_green_level), .o_blue(o_blue_level)
    );

    a_sqrt_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_s0 == v_s1)
        else $error("sqrt lanes out of step");
    a_weights: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        v_d && !z_d |-> (w0 + w1 <= WT_W'(1 << FRAC_W)))
        else $error("weights exceed one");
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vb |-> ##60 o_done)
        else $error("item lost in pipeline");
endmodule

>>> rtl/cdcg_sqrt.sv
// Pipelined restoring integer square root, one result bit per stage.
`timescale 1ns / 1ps
module cdcg_sqrt (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cdcg_pkg::RAD_W-1:0]    i_rad,
    output logic                          o_valid,
    output logic [cdcg_pkg::DIST_W-1:0]   o_root
);
    import cdcg_pkg::*;
    localparam int RW = 2 * SQRT_STEPS;  // padded radicand width

    logic [SQRT_STEPS:0]                r_vld;
    logic [RW-1:0]                      r_rem  [SQRT_STEPS+1];
    logic [RW-1:0]                      r_left [SQRT_STEPS+1];
    logic [DIST_W-1:0]                  r_res  [SQRT_STEPS+1];

    always_comb begin
        r_rem[0]  = '0;
        r_left[0] = {{(RW-RAD_W){1'b0}}, i_rad};
        r_res[0]  = '0;
        r_vld[0]  = i_valid;
    end

    // one stage per bit: bring down two radicand bits, try 4*root+1
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_st
        logic [RW-1:0] n_rem;
        logic [RW-1:0] n_trial;
        logic [RW-1:0] n_sub;
        always_comb begin
            n_rem   = {r_rem[k][RW-3:0], r_left[k][RW-1:RW-2]};
            n_trial = {{(RW-DIST_W-2){1'b0}}, r_res[k], 2'b01};
            n_sub   = n_rem - n_trial;
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_left[k+1] <= {r_left[k][RW-3:0], 2'b00};
            if (n_rem >= n_trial) begin
                r_rem[k+1] <= n_sub;
                r_res[k+1] <= {r_res[k][DIST_W-2:0], 1'b1};
            end else begin
                r_rem[k+1] <= n_rem;
                r_res[k+1] <= {r_res[k][DIST_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[SQRT_STEPS];
    assign o_root  = r_res[SQRT_STEPS];
endmodule

>>> rtl/cdcg_div.sv
// Pipelined restoring divider for the two weights, one quotient bit per stage.
`timescale 1ns / 1ps
module cdcg_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [cdcg_pkg::DIST_W-1:0]   i_d0,
    input  logic [cdcg_pkg::DIST_W-1:0]   i_d1,
    input  cdcg_pkg::t_colors             i_col,
    output logic                          o_valid,
    output logic                          o_zero,
    output logic [cdcg_pkg::WT_W-1:0]     o_w0,
    output logic [cdcg_pkg::WT_W-1:0]     o_w1,
    output cdcg_pkg::t_colors             o_col
);
    import cdcg_pkg::*;
    localparam int RMW = SUM_W + 1;

    logic [DIV_STEPS:0]   r_vld;
    logic [SUM_W-1:0]     r_s    [DIV_STEPS+1];
    logic [NUM_W-1:0]     r_na   [DIV_STEPS+1];
    logic [NUM_W-1:0]     r_nb   [DIV_STEPS+1];
    logic [RMW-1:0]       r_ra   [DIV_STEPS+1];
    logic [RMW-1:0]       r_rb   [DIV_STEPS+1];
    t_colors              r_c    [DIV_STEPS+1];

    always_comb begin
        r_vld[0] = i_valid;
        r_s[0]   = {1'b0, i_d0} + {1'b0, i_d1};
        r_na[0]  = {i_d1, {FRAC_W{1'b0}}};
        r_nb[0]  = {i_d0, {FRAC_W{1'b0}}};
        r_ra[0]  = '0;
        r_rb[0]  = '0;
        r_c[0]   = i_col;
    end

    // numerator register shifts quotient bits in as it shifts dividend out
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_st
        logic [RMW-1:0] n_ta, n_tb;
        always_comb begin
            n_ta = {r_ra[k][RMW-2:0], r_na[k][NUM_W-1]};
            n_tb = {r_rb[k][RMW-2:0], r_nb[k][NUM_W-1]};
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else begin
                r_vld[k+1] <= r_vld[k];
            end
            r_s[k+1] <= r_s[k];
            r_c[k+1] <= r_c[k];
            if (n_ta >= {1'b0, r_s[k]}) begin
                r_ra[k+1] <= n_ta - {1'b0, r_s[k]};
                r_na[k+1] <= {r_na[k][NUM_W-2:0], 1'b1};
            end else begin
                r_ra[k+1] <= n_ta;
                r_na[k+1] <= {r_na[k][NUM_W-2:0], 1'b0};
            end
            if (n_tb >= {1'b0, r_s[k]}) begin
                r_rb[k+1] <= n_tb - {1'b0, r_s[k]};
                r_nb[k+1] <= {r_nb[k][NUM_W-2:0], 1'b1};
            end else begin
                r_rb[k+1] <= n_tb;
                r_nb[k+1] <= {r_nb[k][NUM_W-2:0], 1'b0};
            end
        end
    end

    assign o_valid = r_vld[DIV_STEPS];
    assign o_zero  = (r_s[DIV_STEPS] == '0);
    assign o_w0    = r_na[DIV_STEPS][WT_W-1:0];
    assign o_w1    = r_nb[DIV_STEPS][WT_W-1:0];
    assign o_col   = r_c[DIV_STEPS];
endmodule

>>> rtl/cdcg_blend.sv
// Two-stage color blend: products, then sum, round and saturate, or the start color when the weight sum is zero.
`timescale 1ns / 1ps
module cdcg_blend (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_zero,
    input  logic [cdcg_pkg::WT_W-1:0]     i_w0,
    input  logic [cdcg_pkg::WT_W-1:0]     i_w1,
    input  cdcg_pkg::t_colors             i_col,
    output logic                          o_valid,
    output cdcg_pkg::t_chan               o_red,
    output cdcg_pkg::t_chan               o_green,
    output cdcg_pkg::t_chan               o_blue
);
    import cdcg_pkg::*;
    localparam int PW = CHANNEL_BITS + WT_W;

    logic          r_v1, r_z1, r_v2;
    logic [PW-1:0] r_p0 [3];
    logic [PW-1:0] r_p1 [3];
    t_chan         r_s1 [3];
    t_chan         r_out [3];
    t_chan         n_s [3];
    t_chan         n_e [3];

    always_comb begin
        n_s[0] = i_col.s_red;  n_s[1] = i_col.s_green;  n_s[2] = i_col.s_blue;
        n_e[0] = i_col.e_red;  n_e[1] = i_col.e_green;  n_e[2] = i_col.e_blue;
    end

    for (genvar c = 0; c < 3; c++) begin : g_ch
        logic [PW:0] n_sum;
        logic [PW:0] n_lvl;
        always_comb begin
            n_sum = {1'b0, r_p0[c]} + {1'b0, r_p1[c]} + (PW+1)'(1 << (FRAC_W-1));
            n_lvl = n_sum >> FRAC_W;
        end
        always_ff @(posedge i_clk) begin
            r_p0[c] <= PW'(n_s[c]) * PW'(i_w0);
            r_p1[c] <= PW'(n_e[c]) * PW'(i_w1);
            r_s1[c] <= n_s[c];
            if (r_z1) begin
                r_out[c] <= r_s1[c];
            end else if (n_lvl > (PW+1)'({CHANNEL_BITS{1'b1}})) begin
                r_out[c] <= '1;
            end else begin
                r_out[c] <= n_lvl[CHANNEL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_z1 <= i_zero;
    end

    assign o_valid = r_v2;
    assign o_red   = r_out[0];
    assign o_green = r_out[1];
    assign o_blue  = r_out[2];
endmodule
